### hw/rtl/cms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Count-min sketch package
// Shared constants, types and register indexes for the sketch engine.
// ----------------------------------------------------------------------------
package cms_pkg;
    localparam int ROWS_DEF = 4;
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int WORD_W = 32;
    localparam int COEF_W = 64;
    localparam int CFG_IDX_W = 3;
    localparam int COEF_REGS = 4;

    localparam logic [CFG_IDX_W-1:0] REG_PRIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3  = 3'd5;

    localparam logic [WORD_W-1:0] PRIME_RST = 32'd2147483647;
    localparam logic [10:0] COLS_RST = 11'd1024;
    localparam logic [COEF_W-1:0] COEF_RST = 64'h0000_0001_0000_0000;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        t_ST_CLEAR, t_ST_IDLE, t_ST_MUL_START, t_ST_MUL, t_ST_MODP_START, t_ST_MODP,
        t_ST_MODW_START, t_ST_MODW, t_ST_READ, t_ST_WAIT, t_ST_WRITE, t_ST_OUT
    } t_state;
endpackage

### hw/rtl/cms_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Count-min sketch stream interface
// Valid/ready channel with a parameterized payload.
// ----------------------------------------------------------------------------
interface cms_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/cms_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Count-min sketch RAM
// Single-port generic RAM with registered read.
// ----------------------------------------------------------------------------
module cms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### hw/rtl/cms_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Count-min sketch serial multiply-add
// Computes (a * x + b) mod 2^32 by shift and add, one bit of x per cycle.
// ----------------------------------------------------------------------------
module cms_mul
    import cms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_x,
    input  logic [WORD_W-1:0] i_b,
    output logic              o_done,
    output logic [WORD_W-1:0] o_prod
);
    logic [WORD_W-1:0] r_acc, r_mc, r_x;
    logic [5:0] r_cnt;
    logic r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_acc  <= i_b;
                r_mc   <= i_a;
                r_x    <= i_x;
            end else if (r_busy) begin
                if (r_x[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc  <= r_mc << 1;
                r_x   <= r_x >> 1;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_prod = r_acc;
endmodule

### hw/rtl/cms_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Count-min sketch serial remainder unit
// Restoring division, one quotient bit per cycle, yields n mod d.
// ----------------------------------------------------------------------------
module cms_div
    import cms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_num,
    input  logic [WORD_W-1:0] i_den,
    output logic              o_done,
    output logic [WORD_W-1:0] o_rem
);
    logic [WORD_W-1:0] r_rem, r_num, r_den;
    logic [5:0] r_cnt;
    logic r_busy;
    logic [WORD_W:0] w_trial;

    assign w_trial = {r_rem, r_num[WORD_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_rem  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (w_trial >= {1'b0, r_den}) begin
                    r_rem <= WORD_W'(w_trial - {1'b0, r_den});
                end else begin
                    r_rem <= w_trial[WORD_W-1:0];
                end
                r_num <= r_num << 1;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_rem = r_rem;
endmodule

### hw/rtl/count_min_sketch_update_query.sv
`timescale 1ns / 1ps
// Each row runs a bit-serial multiply, a remainder by the prime and a remainder by
// the column count, then a counter read; an update also writes the counter back. A
// zero prime skips the first remainder. One item is in flight at a time: a new item
// is accepted only once the last one is through. After reset a clearing pass over all
// ROWS * MAX_COLUMNS counters zeroes them before the first item is accepted;
// configuration is taken during it.
// ----------------------------------------------------------------------------
// Count-min sketch update and query engine
// Hashes each item per row, updates counters or returns the row minimum with the stream total.
// ----------------------------------------------------------------------------
module count_min_sketch_update_query
    import cms_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    cms_if.sink                  in_ch,
    cms_if.source                out_ch
);
    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DEPTH = ROWS * MAX_COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);

    t_state r_state, n_state;
    logic [WORD_W-1:0] r_prime;
    logic [10:0] r_cols;
    logic [COEF_W-1:0] r_coef [COEF_REGS];
    logic [WORD_W-1:0] r_total, r_best, r_h, r_item, r_count;
    logic r_kind;
    logic [ROW_W-1:0] r_row;
    logic [ADDR_W-1:0] r_clr;
    logic [COL_W-1:0] r_col;
    logic r_ovalid;
    logic [WORD_W-1:0] r_oest, r_otot;

    logic w_mul_start, w_mul_done, w_div_start, w_div_done;
    logic [WORD_W-1:0] w_prod, w_rem, w_den, w_div_num, w_eff_cols;
    logic [COEF_W-1:0] w_coef;
    logic w_ram_we;
    logic [ADDR_W-1:0] w_addr;
    logic [WORD_W-1:0] w_rdata, w_wdata;
    logic w_last_row;

    assign w_coef = r_coef[2'(r_row)];
    assign w_last_row = (r_row == ROW_W'(ROWS - 1));

    always_comb begin
        if (r_cols == 11'd0) begin
            w_eff_cols = 32'd1;
        end else if ({21'd0, r_cols} > 32'(MAX_COLUMNS)) begin
            w_eff_cols = 32'(MAX_COLUMNS);
        end else begin
            w_eff_cols = {21'd0, r_cols};
        end
    end

    assign w_den = (r_state == t_ST_MODP_START) ? r_prime : w_eff_cols;
    assign w_div_num = (r_state == t_ST_MODP_START) ? w_prod : r_h;

    cms_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mul_start),
        .i_a(w_coef[COEF_W-1:WORD_W]), .i_x(r_item), .i_b(w_coef[WORD_W-1:0]),
        .o_done(w_mul_done), .o_prod(w_prod)
    );

    cms_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_div_num), .i_den(w_den), .o_done(w_div_done), .o_rem(w_rem)
    );

    cms_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_ram_we), .i_addr(w_addr),
        .i_wdata(w_wdata), .o_rdata(w_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            t_ST_CLEAR: if (r_clr == ADDR_W'(DEPTH - 1)) n_state = t_ST_IDLE;
            t_ST_IDLE: if (in_ch.valid) n_state = t_ST_MUL_START;
            t_ST_MUL_START: n_state = t_ST_MUL;
            t_ST_MUL: if (w_mul_done) n_state = t_ST_MODP_START;
            t_ST_MODP_START: n_state = (r_prime == '0) ? t_ST_MODW_START : t_ST_MODP;
            t_ST_MODP: if (w_div_done) n_state = t_ST_MODW_START;
            t_ST_MODW_START: n_state = t_ST_MODW;
            t_ST_MODW: if (w_div_done) n_state = t_ST_READ;
            t_ST_READ: n_state = t_ST_WAIT;
            t_ST_WAIT: begin
                if (r_kind == KIND_UPDATE) begin
                    n_state = t_ST_WRITE;
                end else if (w_last_row) begin
                    n_state = t_ST_OUT;
                end else begin
                    n_state = t_ST_MUL_START;
                end
            end
            t_ST_WRITE: n_state = w_last_row ? t_ST_IDLE : t_ST_MUL_START;
            t_ST_OUT: if (!r_ovalid || out_ch.ready) n_state = t_ST_IDLE;
            default: n_state = t_ST_IDLE;
        endcase
    end

    always_comb begin
        in_ch.ready = (r_state == t_ST_IDLE);
        w_mul_start = (r_state == t_ST_MUL_START);
        w_div_start = (r_state == t_ST_MODP_START && r_prime != '0) ||
                      (r_state == t_ST_MODW_START);
        w_ram_we = (r_state == t_ST_CLEAR) || (r_state == t_ST_WRITE);
        w_wdata = (r_state == t_ST_CLEAR) ? '0 : w_rdata + r_count;
        w_addr = (r_state == t_ST_CLEAR) ? r_clr :
                 ADDR_W'({r_row, r_col});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ST_CLEAR;
            r_clr <= '0;
            r_total <= '0;
            r_ovalid <= 1'b0;
            r_prime <= PRIME_RST;
            r_cols <= COLS_RST;
            for (int i = 0; i < COEF_REGS; i++) r_coef[i] <= COEF_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_PRIME) r_prime <= i_cfg_data[WORD_W-1:0];
                else if (i_cfg_idx == REG_COLS) r_cols <= i_cfg_data[10:0];
                else if (i_cfg_idx >= REG_ROW0 && i_cfg_idx <= REG_ROW3)
                    r_coef[2'(i_cfg_idx - REG_ROW0)] <= i_cfg_data;
            end
            if (r_state == t_ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == t_ST_IDLE && in_ch.valid) begin
                r_kind <= in_ch.data[2*WORD_W];
                r_item <= in_ch.data[2*WORD_W-1:WORD_W];
                r_count <= in_ch.data[WORD_W-1:0];
                r_row <= '0;
                r_best <= '1;
            end
            if (r_state == t_ST_MODP_START) r_h <= w_prod;
            if (r_state == t_ST_MODP && w_div_done) r_h <= w_rem;
            if (r_state == t_ST_MODW && w_div_done) r_col <= w_rem[COL_W-1:0];
            if (r_state == t_ST_WAIT) begin
                if (r_kind == KIND_QUERY) begin
                    if (w_rdata < r_best) r_best <= w_rdata;
                    if (!w_last_row) r_row <= r_row + 1'b1;
                end
            end
            if (r_state == t_ST_WRITE) begin
                if (w_last_row) r_total <= r_total + r_count;
                else r_row <= r_row + 1'b1;
            end
            if (r_state == t_ST_OUT && (!r_ovalid || out_ch.ready)) begin
                r_ovalid <= 1'b1;
                r_oest <= r_best;
                r_otot <= r_total;
            end else if (out_ch.valid && out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign out_ch.valid = r_ovalid;
    assign out_ch.data = {r_oest, r_otot};

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> r_state == t_ST_IDLE) else $error("ready outside idle");
    a_no_write_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ram_we && r_state != t_ST_CLEAR) |-> r_kind == KIND_UPDATE)
        else $error("counter written on query");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !out_ch.ready) |=> r_ovalid && $stable(r_oest))
        else $error("result dropped");
endmodule

### tb/tb_count_min_sketch_update_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Count-min sketch engine testbench
// Streams updates and point queries through the engine under several hash
// and column settings and idle patterns. A local sketch model predicts every
// query answer, and each answer is compared field by field as it arrives.
// ----------------------------------------------------------------------------
module tb_count_min_sketch_update_query;
    import cms_pkg::*;

    localparam int IN_W = 1 + 2 * WORD_W;
    localparam int OUT_W = 2 * WORD_W;
    localparam int SETTLE_CYCLES = 600;
    localparam int HOLD_CYCLES = 3000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] item;
        logic [WORD_W-1:0] count;
    } t_request;

    typedef struct packed {
        logic [WORD_W-1:0] estimate;
        logic [WORD_W-1:0] stream_total;
    } t_answer;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COEF_W-1:0] i_cfg_data;

    cms_if #(.W(IN_W)) in_ch ();
    cms_if #(.W(OUT_W)) out_ch ();

    count_min_sketch_update_query DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    // Local sketch state.
    logic [WORD_W-1:0] sk_prime;
    logic [10:0] sk_cols;
    logic [COEF_W-1:0] sk_coefs [COEF_REGS];
    logic [WORD_W-1:0] sk_table [ROWS_DEF][MAX_COLUMNS_DEF];
    logic [WORD_W-1:0] sk_total;

    t_request request_queue [$];
    t_answer answer_queue [$];
    t_idle_mode idle_mode;
    int errors;
    int answers_seen;
    int updates_sent;
    int queries_sent;
    int hold_reqs;
    int hold_done;
    int hold_cnt;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("Timeout with %0d answers outstanding.", answer_queue.size());
        $display("** count_min_sketch_update_query: FAILED **");
        $finish;
    end

    function automatic int unsigned sketch_column(int row, logic [WORD_W-1:0] item);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] h;
        logic [WORD_W-1:0] w;
        a = sk_coefs[row][63:32];
        b = sk_coefs[row][31:0];
        h = a * item + b;
        if (sk_prime != 32'd0) h = h % sk_prime;
        w = {21'd0, sk_cols};
        if (w == 32'd0) w = 32'd1;
        if (w > 32'(MAX_COLUMNS_DEF)) w = 32'(MAX_COLUMNS_DEF);
        return h % w;
    endfunction

    task automatic apply_request(t_request req);
        t_answer ans;
        logic [WORD_W-1:0] v;
        int unsigned c;
        if (req.kind == KIND_UPDATE) begin
            for (int r = 0; r < ROWS_DEF; r++) begin
                c = sketch_column(r, req.item);
                sk_table[r][c] = sk_table[r][c] + req.count;
            end
            sk_total = sk_total + req.count;
        end else begin
            ans.estimate = '1;
            for (int r = 0; r < ROWS_DEF; r++) begin
                v = sk_table[r][sketch_column(r, req.item)];
                if (v < ans.estimate) ans.estimate = v;
            end
            ans.stream_total = sk_total;
            answer_queue.push_back(ans);
        end
    endtask

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
        errors++;
        $display("Mismatch at %0t: %s got %h, expected %h", $realtime, what, got, want);
    endtask

    // Sender.
    always @(posedge i_clk) begin
        logic offer;
        t_request req;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            offer = request_queue.size() > 0;
            if ((idle_mode == IDLE_SENDER && $urandom_range(99) < 78)
                    || (idle_mode == IDLE_BOTH && $urandom_range(99) < 9)) begin
                offer = 1'b0;
            end
            if (offer) begin
                req = request_queue.pop_front();
                in_ch.data <= req;
            end
            in_ch.valid <= offer;
        end
    end

    // Receiver, with a long hold-off on request.
    always @(posedge i_clk) begin
        logic rdy;
        rdy = 1'b1;
        if ((idle_mode == IDLE_RECEIVER && $urandom_range(99) < 78)
                || (idle_mode == IDLE_BOTH && $urandom_range(99) < 9)) begin
            rdy = 1'b0;
        end
        if (hold_done < hold_reqs) begin
            rdy = 1'b0;
            if (hold_cnt == HOLD_CYCLES) begin
                hold_cnt <= 0;
                hold_done <= hold_done + 1;
            end else begin
                hold_cnt <= hold_cnt + 1;
            end
        end
        out_ch.ready <= rdy;
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            apply_request(t_request'(in_ch.data));
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = t_answer'(out_ch.data);
            answers_seen++;
            if (answer_queue.size() == 0) begin
                errors++;
                $display("Unexpected answer at %0t: %h", $realtime, got);
            end else begin
                want = answer_queue.pop_front();
                if (got.estimate !== want.estimate)
                    report_mismatch("estimate", got.estimate, want.estimate);
                if (got.stream_total !== want.stream_total)
                    report_mismatch("stream_total", got.stream_total, want.stream_total);
            end
        end
    end

    task automatic wait_drained();
        while (request_queue.size() > 0 || in_ch.valid || answer_queue.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        if (idx == REG_PRIME) sk_prime = value[31:0];
        else if (idx == REG_COLS) sk_cols = value[10:0];
        else sk_coefs[idx - REG_ROW0] = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_request(logic kind, logic [WORD_W-1:0] item, logic [WORD_W-1:0] count);
        t_request req;
        req.kind = kind;
        req.item = item;
        req.count = count;
        request_queue.push_back(req);
        if (kind == KIND_UPDATE) updates_sent++;
        else queries_sent++;
    endtask

    task automatic random_phase(int n);
        logic [WORD_W-1:0] keys [16];
        logic [WORD_W-1:0] cnt;
        for (int k = 0; k < 16; k++) keys[k] = $urandom;
        keys[0] = '0;
        keys[1] = '1;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: cnt = $urandom;
                1: cnt = $urandom_range(15);
                2: cnt = '1;
                default: cnt = $urandom_range(1000);
            endcase
            push_request($urandom_range(1) ? KIND_QUERY : KIND_UPDATE,
                $urandom_range(9) == 0 ? $urandom : keys[$urandom_range(15)], cnt);
        end
    endtask

    task automatic write_hash(logic [WORD_W-1:0] prime, logic [10:0] cols, int coef_mode);
        logic [COEF_W-1:0] c;
        write_reg(REG_PRIME, {32'd0, prime});
        write_reg(REG_COLS, {53'd0, cols});
        for (int r = 0; r < COEF_REGS; r++) begin
            case (coef_mode)
                0: c = '0;
                1: c = '1;
                default: c = {$urandom, $urandom};
            endcase
            write_reg(CFG_IDX_W'(REG_ROW0 + r), c);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        idle_mode = IDLE_NONE;
        errors = 0;
        answers_seen = 0;
        updates_sent = 0;
        queries_sent = 0;
        hold_reqs = 0;
        hold_done = 0;
        hold_cnt = 0;
        sk_prime = PRIME_RST;
        sk_cols = COLS_RST;
        for (int r = 0; r < COEF_REGS; r++) sk_coefs[r] = COEF_RST;
        for (int r = 0; r < ROWS_DEF; r++)
            for (int c = 0; c < MAX_COLUMNS_DEF; c++) sk_table[r][c] = '0;
        sk_total = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under reset settings.
        push_request(KIND_QUERY, 32'h0, 32'h0);
        push_request(KIND_UPDATE, 32'h0, 32'h0);
        push_request(KIND_UPDATE, 32'h0, 32'h1);
        push_request(KIND_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_request(KIND_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_request(KIND_UPDATE, 32'hFFFF_FFFF, 32'h2);
        push_request(KIND_QUERY, 32'hFFFF_FFFF, 32'h0);
        push_request(KIND_QUERY, 32'h0, 32'hFFFF_FFFF);
        push_request(KIND_UPDATE, 32'h7FFF_FFFF, 32'h5555_5555);
        push_request(KIND_QUERY, 32'h7FFF_FFFF, 32'h0);
        push_request(KIND_QUERY, 32'h0000_0400, 32'h0);
        push_request(KIND_QUERY, 32'h1234_5678, 32'hAAAA_AAAA);
        wait_drained();

        // Prime zero, columns zero, zero coefficients.
        write_hash(32'h0, 11'd0, 0);
        push_request(KIND_UPDATE, 32'h5, 32'h3);
        push_request(KIND_QUERY, 32'h9, 32'h0);
        wait_drained();
        // Prime one, columns too many, all-ones coefficients.
        write_hash(32'h1, 11'h7FF, 1);
        push_request(KIND_UPDATE, 32'hDEAD_BEEF, 32'h7);
        push_request(KIND_QUERY, 32'h1, 32'h0);
        wait_drained();

        idle_mode = IDLE_NONE;
        write_hash(32'd2, 11'd1024, 2);
        random_phase(220);
        wait_drained();

        idle_mode = IDLE_SENDER;
        write_hash(32'hFFFF_FFFF, 11'd1, 2);
        random_phase(220);
        wait_drained();

        idle_mode = IDLE_RECEIVER;
        write_hash(32'd65521, 11'd7, 2);
        random_phase(220);
        hold_reqs = hold_reqs + 1;
        random_phase(60);
        wait_drained();

        idle_mode = IDLE_BOTH;
        write_hash(32'd0, 11'd1000, 2);
        random_phase(220);
        wait_drained();

        idle_mode = IDLE_NONE;
        write_hash(32'd2147483647, 11'd33, 2);
        hold_reqs = hold_reqs + 1;
        random_phase(200);
        wait_drained();

        idle_mode = IDLE_SENDER;
        write_hash(32'd1, 11'd512, 2);
        random_phase(150);
        wait_drained();

        idle_mode = IDLE_BOTH;
        write_hash(32'd4093, 11'd0, 2);
        random_phase(220);
        wait_drained();

        $display("Covered %0d updates and %0d queries, %0d answers checked,", updates_sent,
            queries_sent, answers_seen);
        $display("over ten hash settings with idle, stall and hold-off patterns.");
        if (errors == 0) begin
            $display("** count_min_sketch_update_query: PASSED **");
        end else begin
            $display("** count_min_sketch_update_query: FAILED **");
        end
        $finish;
    end
endmodule

### files.f
hw/rtl/cms_pkg.sv
hw/rtl/cms_if.sv
hw/rtl/cms_ram.sv
hw/rtl/cms_mul.sv
hw/rtl/cms_div.sv
hw/rtl/count_min_sketch_update_query.sv
tb/tb_count_min_sketch_update_query.sv
